// ===== design/ort_pkg.sv =====
// Shared types and fixed field widths for the optimal-replacement occupancy tracker.
package ort_pkg;

  localparam int SET_IDX_W  = 6;
  localparam int ADDR_W     = 64;
  localparam int OCC_W      = 5;
  localparam int WAYS_W     = 5;
  localparam int MULT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PROD_W     = WAYS_W + MULT_W;

  localparam logic [OCC_W-1:0] OCC_MAX = 5'd31;

  localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd16;
  localparam logic [MULT_W-1:0] MULT_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_WAYS   = 1'b0,
    REG_HISTORY_MULT = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_META   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_INC    = 6'b010000,
    ST_APPEND = 6'b100000
  } state_t;

endpackage

// ===== design/optimal_replacement_occupancy_tracker.sv =====
// Top level: per-set window scan and occupancy update under a small sequencer.
// A set index of SET_COUNT or more gives a miss straight from idle; an empty window goes
// straight to append; a miss checks n entries, a hit checks n entries and increments m.
// One item at a time: busy high until the result's cycle.
// The window memory port (one read, one write per cycle) sets the per-entry cost.
// Reset: a clearing pass over all SET_COUNT sets clears the per-set fill and oldest state, busy high.
module optimal_replacement_occupancy_tracker #(
  parameter int SET_COUNT  = 64,
  parameter int MAX_WINDOW = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ort_pkg::SET_IDX_W-1:0]  in_set_index,
  input  logic [ort_pkg::ADDR_W-1:0]     in_address,
  output logic                           out_valid,
  output logic                           out_opt_hit,
  input  logic                           cfg_we,
  input  logic [ort_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ort_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ort_pkg::*;

  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int MEM_D  = SET_COUNT * MAX_WINDOW;
  localparam int MEM_AW = $clog2(MEM_D);

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(MAX_WINDOW - 1);
  localparam logic [FILL_W:0]   WIN_WRAP  = (FILL_W + 1)'(MAX_WINDOW);
  localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(SET_COUNT - 1);

  logic [ADDR_W-1:0] addr_mem [MEM_D];
  logic [OCC_W-1:0]  occ_mem  [MEM_D];
  logic [POS_W-1:0]  oldest_mem [SET_COUNT];
  logic [FILL_W-1:0] fill_mem   [SET_COUNT];

  state_t            state_r, state_nxt;
  logic [WAYS_W-1:0] ways_r;
  logic [MULT_W-1:0] mult_r;
  logic [SET_W-1:0]  set_r, set_nxt;
  logic [ADDR_W-1:0] key_r, key_nxt;
  logic [SET_W-1:0]  clr_r, clr_nxt;
  logic [MEM_AW-1:0] base_r, base_nxt;
  logic [POS_W-1:0]  oldest_r, oldest_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [FILL_W-1:0] scan_left_r, scan_left_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [POS_W-1:0]  chk_pos_r, chk_pos_nxt;
  logic [FILL_W-1:0] chk_k_r, chk_k_nxt;
  logic [POS_W-1:0]  inc_pos_r, inc_pos_nxt;
  logic [FILL_W-1:0] inc_left_r, inc_left_nxt;
  logic              wb_valid_r, wb_valid_nxt;
  logic [POS_W-1:0]  wb_pos_r, wb_pos_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic [ADDR_W-1:0] addr_q;
  logic [OCC_W-1:0]  occ_q;
  logic [POS_W-1:0]  meta_oldest_q;
  logic [FILL_W-1:0] meta_fill_q;

  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] wr_addr;
  logic              addr_we;
  logic              occ_we;
  logic [OCC_W-1:0]  occ_wdata;
  logic              meta_we;
  logic [SET_W-1:0]  meta_waddr;
  logic [POS_W-1:0]  meta_oldest_wd;
  logic [FILL_W-1:0] meta_fill_wd;
  logic [SET_W-1:0]  meta_raddr;

  logic              accept;
  logic              set_oob;
  logic [PROD_W-1:0] prod;
  logic [FILL_W-1:0] win_len;
  logic [FILL_W:0]   start_sum;
  logic [POS_W-1:0]  start_pos;
  logic              drop;
  logic [POS_W-1:0]  app_oldest;
  logic [FILL_W-1:0] app_fill;
  logic [FILL_W:0]   app_sum;
  logic [POS_W-1:0]  app_pos;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign set_oob     = (32'(in_set_index) >= SET_COUNT);
  assign out_valid   = out_valid_r;
  assign out_opt_hit = out_hit_r;

  always_comb begin
    prod = PROD_W'(ways_r) * PROD_W'(mult_r);
    if (32'(prod) > MAX_WINDOW) begin
      win_len = FILL_W'(MAX_WINDOW);
    end else if (prod == '0) begin
      win_len = FILL_W'(1);
    end else begin
      win_len = FILL_W'(prod);
    end
  end

  always_comb begin
    start_sum = (FILL_W + 1)'(meta_oldest_q) + (FILL_W + 1)'(meta_fill_q)
              - (FILL_W + 1)'(1);
    if (start_sum >= WIN_WRAP) begin
      start_pos = POS_W'(start_sum - WIN_WRAP);
    end else begin
      start_pos = POS_W'(start_sum);
    end
  end

  always_comb begin
    drop = (fill_r >= win_len);
    if (drop) begin
      app_oldest = (oldest_r == POS_LAST) ? '0 : oldest_r + POS_W'(1);
      app_fill   = fill_r - FILL_W'(1);
    end else begin
      app_oldest = oldest_r;
      app_fill   = fill_r;
    end
    app_sum = (FILL_W + 1)'(app_oldest) + (FILL_W + 1)'(app_fill);
    if (app_sum >= WIN_WRAP) begin
      app_pos = POS_W'(app_sum - WIN_WRAP);
    end else begin
      app_pos = POS_W'(app_sum);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    set_nxt        = set_r;
    key_nxt        = key_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    oldest_nxt     = oldest_r;
    fill_nxt       = fill_r;
    scan_pos_nxt   = scan_pos_r;
    scan_left_nxt  = scan_left_r;
    chk_valid_nxt  = 1'b0;
    chk_pos_nxt    = chk_pos_r;
    chk_k_nxt      = chk_k_r;
    inc_pos_nxt    = inc_pos_r;
    inc_left_nxt   = inc_left_r;
    wb_valid_nxt   = 1'b0;
    wb_pos_nxt     = wb_pos_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = out_hit_r;
    rd_addr        = base_r + MEM_AW'(scan_pos_r);
    wr_addr        = base_r + MEM_AW'(app_pos);
    addr_we        = 1'b0;
    occ_we         = 1'b0;
    occ_wdata      = '0;
    meta_we        = 1'b0;
    meta_waddr     = set_r;
    meta_oldest_wd = app_oldest;
    meta_fill_wd   = app_fill + FILL_W'(1);
    meta_raddr     = SET_W'(in_set_index);

    case (state_r)
      ST_CLEAR: begin
        meta_we        = 1'b1;
        meta_waddr     = clr_r;
        meta_oldest_wd = '0;
        meta_fill_wd   = '0;
        clr_nxt        = clr_r + SET_W'(1);
        if (clr_r == SET_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (set_oob) begin
            out_valid_nxt = 1'b1;
            out_hit_nxt   = 1'b0;
          end else begin
            set_nxt   = SET_W'(in_set_index);
            key_nxt   = in_address;
            state_nxt = ST_META;
          end
        end
      end
      ST_META: begin
        base_nxt      = MEM_AW'(32'(set_r) * MAX_WINDOW);
        oldest_nxt    = meta_oldest_q;
        fill_nxt      = meta_fill_q;
        hit_nxt       = 1'b0;
        scan_pos_nxt  = start_pos;
        scan_left_nxt = meta_fill_q;
        if (meta_fill_q == '0) begin
          state_nxt = ST_APPEND;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_left_r != '0) begin
          chk_valid_nxt = 1'b1;
          chk_pos_nxt   = scan_pos_r;
          chk_k_nxt     = scan_left_r - FILL_W'(1);
          scan_left_nxt = scan_left_r - FILL_W'(1);
          scan_pos_nxt  = (scan_pos_r == '0) ? POS_LAST : scan_pos_r - POS_W'(1);
        end
        if (chk_valid_r) begin
          if (occ_q == ways_r) begin
            chk_valid_nxt = 1'b0;
            state_nxt     = ST_APPEND;
          end else if (addr_q == key_r) begin
            chk_valid_nxt = 1'b0;
            hit_nxt       = 1'b1;
            inc_pos_nxt   = chk_pos_r;
            inc_left_nxt  = fill_r - chk_k_r;
            state_nxt     = ST_INC;
          end else if (chk_k_r == '0) begin
            chk_valid_nxt = 1'b0;
            state_nxt     = ST_APPEND;
          end
        end
      end
      ST_INC: begin
        rd_addr = base_r + MEM_AW'(inc_pos_r);
        wr_addr = base_r + MEM_AW'(wb_pos_r);
        if (inc_left_r != '0) begin
          wb_valid_nxt = 1'b1;
          wb_pos_nxt   = inc_pos_r;
          inc_left_nxt = inc_left_r - FILL_W'(1);
          inc_pos_nxt  = (inc_pos_r == POS_LAST) ? '0 : inc_pos_r + POS_W'(1);
        end
        if (wb_valid_r) begin
          occ_we    = 1'b1;
          occ_wdata = (occ_q < OCC_MAX) ? occ_q + OCC_W'(1) : occ_q;
        end
        if (inc_left_r == '0 && !wb_valid_r) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        addr_we       = 1'b1;
        occ_we        = 1'b1;
        occ_wdata     = '0;
        meta_we       = 1'b1;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[wr_addr] <= key_r;
    end
    addr_q <= addr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wdata;
    end
    occ_q <= occ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      oldest_mem[meta_waddr] <= meta_oldest_wd;
      fill_mem[meta_waddr]   <= meta_fill_wd;
    end
    meta_oldest_q <= oldest_mem[meta_raddr];
    meta_fill_q   <= fill_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      chk_valid_r <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ways_r      <= WAYS_RESET;
      mult_r      <= MULT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_valid_r <= chk_valid_nxt;
      wb_valid_r  <= wb_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CACHE_WAYS:   ways_r <= cfg_wdata[WAYS_W-1:0];
          REG_HISTORY_MULT: mult_r <= cfg_wdata[MULT_W-1:0];
          default: begin
            ways_r <= ways_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r       <= set_nxt;
    key_r       <= key_nxt;
    base_r      <= base_nxt;
    oldest_r    <= oldest_nxt;
    fill_r      <= fill_nxt;
    scan_pos_r  <= scan_pos_nxt;
    scan_left_r <= scan_left_nxt;
    chk_pos_r   <= chk_pos_nxt;
    chk_k_r     <= chk_k_nxt;
    inc_pos_r   <= inc_pos_nxt;
    inc_left_r  <= inc_left_nxt;
    wb_pos_r    <= wb_pos_nxt;
    hit_r       <= hit_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  a_oob_miss: assert property (@(posedge clk) disable iff (!rst_n)
    accept && set_oob |=> out_valid && !out_opt_hit)
    else $error("out-of-range set did not give a miss");

  a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPEND |=> out_valid)
    else $error("append without result strobe");

  a_wb_in_inc: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> state_r == ST_INC)
    else $error("occupancy write-back outside increment pass");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy during clearing pass");

endmodule
